// File: src/rks_pkg.sv
// ----------------------------------------------------------------------------
// rks_pkg: shared types and constants for the recent key set store
// Command codes, controller states and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package rks_pkg;

  localparam int unsigned RING_DEPTH_DEF = 32;
  localparam int unsigned KEY_W          = 64;
  localparam int unsigned CMD_W          = 3;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_HAS    = 3'd2,
    CMD_ADD    = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DISPATCH,
    ST_HAS_RD,
    ST_HAS_CMP,
    ST_RM_RD,
    ST_RM_CMP,
    ST_RM_CHK,
    ST_SH_WR,
    ST_DONE
  } state_e;

  // Datapath operations, one strobe each
  typedef struct packed {
    logic cap;         // capture the accepted beat, rewind scan counters
    logic set_status;  // status word <= payload
    logic do_clear;    // pointer and status word to zero
    logic clr_wr;      // write empty key at scan index, advance index
    logic add_wr;      // write key at pointer, advance pointer
    logic rd_idx;      // read ring at scan index
    logic has_cmp;     // fold compare into found flag, advance index
    logic idx_inc;     // advance scan index
    logic rm_start;    // shift cursor <= scan index
    logic rm_empty;    // free newest slot, step pointer back, count removal
    logic rd_next;     // read ring at cursor + 1
    logic sh_wr;       // write read data at cursor, advance cursor
    logic out_load;    // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             match;     // read data equals key
    logic             idx_last;  // scan index at last slot
    logic             j_at_end;  // cursor at the newest slot
    logic             rem_ok;    // removal budget not spent
  } dp_stat_t;

endpackage

// File: src/rks_ram.sv
// ----------------------------------------------------------------------------
// rks_ram: generic single write port RAM with registered read
// One write and one read per cycle; read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module rks_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rks_datapath.sv
// ----------------------------------------------------------------------------
// rks_datapath: key ring, pointer, counters and status word
// Executes the strobes of the controller and reports compare results.
// ----------------------------------------------------------------------------
module rks_datapath #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rks_pkg::dp_cmd_t              cmd_i,
  output rks_pkg::dp_stat_t             stat_o,
  input  logic [rks_pkg::CMD_W-1:0]     command_i,
  input  logic [rks_pkg::KEY_W-1:0]     payload_i,
  output logic                          found_o,
  output logic [rks_pkg::KEY_W-1:0]     status_value_o
);
  import rks_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned RW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] status_q;
  logic [AW-1:0]    wp_q, idx_q, j_q;
  logic [RW-1:0]    removals_q;
  logic             found_q;
  logic             out_found_q;
  logic [KEY_W-1:0] out_status_q;

  logic [AW-1:0]    wp_nx, wp_m1, j_nx;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [KEY_W-1:0] ram_wdata, ram_rdata;

  assign wp_nx = (wp_q == LAST) ? '0 : wp_q + AW'(1);
  assign wp_m1 = (wp_q == '0) ? LAST : wp_q - AW'(1);
  assign j_nx  = (j_q == LAST) ? '0 : j_q + AW'(1);

  assign ram_we    = cmd_i.clr_wr | cmd_i.add_wr | cmd_i.rm_empty | cmd_i.sh_wr;
  assign ram_waddr = cmd_i.clr_wr ? idx_q : (cmd_i.add_wr ? wp_q : j_q);
  assign ram_wdata = (cmd_i.clr_wr | cmd_i.rm_empty) ? EMPTY_KEY :
                     (cmd_i.add_wr ? key_q : ram_rdata);
  assign ram_raddr = cmd_i.rd_next ? j_nx : idx_q;

  rks_ram #(
    .WIDTH (KEY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q   <= '0;
      wp_q       <= '0;
      idx_q      <= '0;
      j_q        <= '0;
      removals_q <= '0;
      found_q    <= 1'b0;
    end else begin
      if (cmd_i.cap) begin
        idx_q      <= '0;
        removals_q <= '0;
        found_q    <= 1'b0;
      end
      if (cmd_i.set_status) begin
        status_q <= key_q;
      end
      if (cmd_i.do_clear) begin
        status_q <= '0;
        wp_q     <= '0;
      end
      if (cmd_i.add_wr) begin
        wp_q <= wp_nx;
      end
      if (cmd_i.clr_wr | cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.has_cmp) begin
        found_q <= found_q | (ram_rdata == key_q);
        idx_q   <= idx_q + AW'(1);
      end
      if (cmd_i.rm_start) begin
        j_q <= idx_q;
      end
      if (cmd_i.sh_wr) begin
        j_q <= j_nx;
      end
      if (cmd_i.rm_empty) begin
        wp_q       <= wp_m1;
        removals_q <= removals_q + RW'(1);
      end
    end
  end

  // Beat and result registers carry no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cmd_q <= command_i;
      key_q <= payload_i;
    end
    if (cmd_i.out_load) begin
      out_found_q  <= found_q;
      out_status_q <= status_q;
    end
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.match    = (ram_rdata == key_q);
  assign stat_o.idx_last = (idx_q == LAST);
  assign stat_o.j_at_end = (j_q == wp_m1);
  assign stat_o.rem_ok   = (removals_q < RW'(RING_DEPTH));

  assign found_o        = out_found_q;
  assign status_value_o = out_status_q;

  a_wp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wp_q} < (AW+1)'(RING_DEPTH))
    else $error("write pointer beyond ring depth");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rm_empty |-> (removals_q < RW'(RING_DEPTH)))
    else $error("removal beyond budget");

  a_rem_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rm_empty |=> (removals_q == $past(removals_q) + RW'(1)))
    else $error("removal count did not advance");

endmodule

// File: src/rks_ctrl.sv
// ----------------------------------------------------------------------------
// rks_ctrl: sequencer of the recent key set store
// Runs the clearing pass, dispatches commands and drives the result valid.
// ----------------------------------------------------------------------------
module rks_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rks_pkg::dp_cmd_t  cmd_o,
  input  rks_pkg::dp_stat_t stat_i
);
  import rks_pkg::*;

  state_e state_q, state_d;
  logic   reply_q, reply_d;
  logic   oval_q, oval_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      reply_q <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      reply_q <= reply_d;
      oval_q  <= oval_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    reply_d    = reply_q;
    oval_d     = oval_q & ~out_ready_i;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.idx_last) begin
          reply_d = 1'b0;
          state_d = reply_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat_i.cmd)
          CMD_SET: begin
            cmd_o.set_status = 1'b1;
            state_d          = ST_DONE;
          end
          CMD_HAS:    state_d = ST_HAS_RD;
          CMD_ADD: begin
            cmd_o.add_wr = 1'b1;
            state_d      = ST_DONE;
          end
          CMD_REMOVE: state_d = ST_RM_RD;
          CMD_CLEAR: begin
            cmd_o.do_clear = 1'b1;
            reply_d        = 1'b1;
            state_d        = ST_CLR;
          end
          default:    state_d = ST_DONE;
        endcase
      end
      ST_HAS_RD: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = ST_HAS_CMP;
      end
      ST_HAS_CMP: begin
        cmd_o.has_cmp = 1'b1;
        state_d       = stat_i.idx_last ? ST_DONE : ST_HAS_RD;
      end
      ST_RM_RD: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = ST_RM_CMP;
      end
      ST_RM_CMP: begin
        if (stat_i.match && stat_i.rem_ok) begin
          cmd_o.rm_start = 1'b1;
          state_d        = ST_RM_CHK;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = stat_i.idx_last ? ST_DONE : ST_RM_RD;
        end
      end
      ST_RM_CHK: begin
        if (stat_i.j_at_end) begin
          cmd_o.rm_empty = 1'b1;
          state_d        = ST_RM_RD;
        end else begin
          cmd_o.rd_next = 1'b1;
          state_d       = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = ST_RM_CHK;
      end
      ST_DONE: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          oval_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = oval_q;

  a_accept_dispatch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DISPATCH))
    else $error("accepted beat not dispatched");

  a_done_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && oval_q && !out_ready_i) |=> (state_q == ST_DONE && oval_q))
    else $error("result overwritten while output stalled");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> oval_q)
    else $error("output load without valid");

endmodule

// File: src/recent_key_set_store.sv
// ----------------------------------------------------------------------------
// recent_key_set_store: ring of recent 64-bit keys with a status word
// Top level; joins the sequencer and the datapath to the stream ports.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one command beat: tuser carries the command code, tdata
//   the 64-bit payload (key for has/add/remove, new value for set). Each beat
//   yields exactly one result beat on the master side: found flag and the
//   status word as it stands after the command.
//   Work per beat (D = RING_DEPTH): get, set, add and unused codes need no
//   scan; has and remove read and compare every ring entry; clear sweeps
//   the ring to empty (one ring entry per cycle); remove also shifts each
//   newer entry down by one slot per removed copy, up to D removals.
//   One beat is processed at a time; the single ring RAM sets the pace.
//   A new beat is taken while the previous result still waits in the output
//   register. When the receiver stalls, the result is held and the next
//   finished result waits inside until the register frees.
//   After reset the ring is swept to empty, one entry at a time, before the
//   first beat is accepted.
// ----------------------------------------------------------------------------
module recent_key_set_store #(
  parameter int unsigned RING_DEPTH = rks_pkg::RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] payload
  input  logic [7:0]  s_axis_tuser,   // [2:0] command, [7:3] zero
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [0] found, [64:1] status_value, [71:65] zero
);
  import rks_pkg::*;

  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  logic             found;
  logic [KEY_W-1:0] status_value;

  // Sequencer: owns the handshakes and the order of ring operations
  rks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // Datapath: ring RAM, pointer, counters, status word and output register
  rks_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .command_i      (s_axis_tuser[CMD_W-1:0]),
    .payload_i      (s_axis_tdata),
    .found_o        (found),
    .status_value_o (status_value)
  );

  // Pack result: found lowest, status word above, zero fill to whole bytes
  assign m_axis_tdata = {7'b0, status_value, found};

endmodule
